// File: hw/rtl/turtle_path_interpreter_defines.svh
// ---------------------------------------------------------------------------
// Turtle path interpreter assertion macros
// Shared concurrent assertion forms for the turtle path interpreter RTL.
// ---------------------------------------------------------------------------
`ifndef TURTLE_PATH_INTERPRETER_DEFINES_SVH
`define TURTLE_PATH_INTERPRETER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TPI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TPI_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/tpi_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Turtle path interpreter package
// Types, register indexes, symbol codes and the sine table.
// ---------------------------------------------------------------------------
package tpi_pkg;

   localparam int unsigned PosW  = 24;
   localparam int unsigned HdgW  = 9;
   localparam int unsigned ProdW = 32;

   // configuration register indexes
   localparam logic [2:0] CSR_STEP_LENGTH   = 3'd0;
   localparam logic [2:0] CSR_TURN_ANGLE    = 3'd1;
   localparam logic [2:0] CSR_START_X       = 3'd2;
   localparam logic [2:0] CSR_START_Y       = 3'd3;
   localparam logic [2:0] CSR_START_HEADING = 3'd4;

   localparam logic [15:0]        STEP_LENGTH_RST   = 16'd256;
   localparam logic signed [9:0]  TURN_ANGLE_RST    = 10'sd60;
   localparam logic signed [23:0] START_X_RST       = 24'sd300800;
   localparam logic signed [23:0] START_Y_RST       = 24'sd121600;
   localparam logic [8:0]         START_HEADING_RST = 9'd270;

   localparam logic [7:0] SYM_A     = 8'h41;
   localparam logic [7:0] SYM_F     = 8'h46;
   localparam logic [7:0] SYM_L     = 8'h4C;
   localparam logic [7:0] SYM_BAR   = 8'h7C;
   localparam logic [7:0] SYM_PLUS  = 8'h2B;
   localparam logic [7:0] SYM_MINUS = 8'h2D;
   localparam logic [7:0] SYM_OPEN  = 8'h5B;
   localparam logic [7:0] SYM_CLOSE = 8'h5D;

   localparam logic [0:0] REQ_SYMBOL  = 1'b0;
   localparam logic [0:0] REQ_RESTART = 1'b1;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_MOVE,
      OP_HALF,
      OP_PLUS,
      OP_MINUS,
      OP_PUSH,
      OP_POP,
      OP_RESTART
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2
   } stack_err_type;

   // one saved turtle: position and heading
   typedef struct packed {
      logic signed [PosW-1:0] x;
      logic signed [PosW-1:0] y;
      logic [HdgW-1:0]        h;
   } turtle_entry_type;

   // round(16384 * sin(d)) for d = 0..90
   localparam logic [14:0] QUARTER_SINE [0:90] = '{
      15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
      15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
      15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
      15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
      15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
      15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
      15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
      15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
      15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
      15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
      15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
      15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
      15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
   };

   // Q1.14 sine of a heading in 0..359, folded onto the quarter wave
   function automatic logic signed [15:0] sin_q14(input logic [8:0] d);
      logic [8:0]  idx;
      logic        neg;
      logic [14:0] mag;
      begin
         if (d <= 9'd90) begin
            idx = d;
            neg = 1'b0;
         end else if (d <= 9'd180) begin
            idx = 9'd180 - d;
            neg = 1'b0;
         end else if (d <= 9'd270) begin
            idx = d - 9'd180;
            neg = 1'b1;
         end else begin
            idx = 9'd360 - d;
            neg = 1'b1;
         end
         mag = QUARTER_SINE[idx[6:0]];
         sin_q14 = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
   endfunction

   // saturate a widened position sum to the signed 24 bit range
   function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
      begin
         if (v > 26'sd8388607) begin
            sat24 = 24'sh7FFFFF;
         end else if (v < -26'sd8388608) begin
            sat24 = 24'sh800000;
         end else begin
            sat24 = v[23:0];
         end
      end
   endfunction

   function automatic op_type decode_op(input logic [0:0] kind, input logic [7:0] sym);
      begin
         if (kind == REQ_RESTART) begin
            decode_op = OP_RESTART;
         end else if (sym >= SYM_A && sym <= SYM_L) begin
            decode_op = OP_MOVE;
         end else begin
            case (sym)
               SYM_BAR:   decode_op = OP_HALF;
               SYM_PLUS:  decode_op = OP_PLUS;
               SYM_MINUS: decode_op = OP_MINUS;
               SYM_OPEN:  decode_op = OP_PUSH;
               SYM_CLOSE: decode_op = OP_POP;
               default:   decode_op = OP_NONE;
            endcase
         end
      end
   endfunction

endpackage

// File: hw/rtl/tpi_stack.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Turtle path interpreter bracket stack
// Single-port-write, registered-read memory of saved turtles.
// ---------------------------------------------------------------------------
module tpi_stack #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned AW    = 6
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  tpi_pkg::turtle_entry_type wr_entry,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output tpi_pkg::turtle_entry_type rd_entry
);
   import tpi_pkg::*;

   turtle_entry_type mem [0:DEPTH-1];
   turtle_entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// File: hw/rtl/turtle_path_interpreter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Turtle path interpreter
// Runs a turtle over a stream of L-system symbols with a bracket stack and a
// running bounding box; one result item per request item.
// ---------------------------------------------------------------------------
//  channel  direction  tdata                              tuser
//  req_     in         symbol[7:0]                        req_type
//  rsp_     out        positions, heading, box, error     line_drawn
//  csr_     in         write only: csr_wr_en/index/wdata  -
//
//  An accepted item passes the entry, lookup and output registers on its
//  way to rsp_tvalid. Moves and unknown symbols sustain one item per cycle
//  while rsp_ is not stalled; turns, brackets and restart hold back the
//  next item, whose sine lookup and stack read use heading and level.
//  Synchronous reset restores the register defaults and the start turtle;
//  the stack memory needs no clearing pass.
//  A stalled rsp_ side holds its item; req_ keeps taking one item into the
//  entry stage until the pipeline behind it is full.
// ---------------------------------------------------------------------------
module turtle_path_interpreter #(
   parameter int unsigned STACK_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] symbol
   input  logic [0:0]   req_tuser,   // [0] req_type
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [23:0] from_x, [47:24] from_y, [71:48] to_x, [95:72] to_y,
   // [104:96] heading_now, [128:105] box_min_x, [152:129] box_max_x,
   // [176:153] box_min_y, [200:177] box_max_y, [202:201] stack_error, rest zero
   output logic [207:0] rsp_tdata,
   output logic [0:0]   rsp_tuser,   // [0] line_drawn
   // configuration write port
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_wdata
);
   import tpi_pkg::*;
   `include "turtle_path_interpreter_defines.svh"

   localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // ---------------- configuration registers ----------------
   logic [15:0]        step_ff;
   logic signed [9:0]  turn_ff;
   logic signed [23:0] start_x_ff;
   logic signed [23:0] start_y_ff;
   logic [8:0]         start_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= STEP_LENGTH_RST;
         turn_ff    <= TURN_ANGLE_RST;
         start_x_ff <= START_X_RST;
         start_y_ff <= START_Y_RST;
         start_h_ff <= START_HEADING_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STEP_LENGTH:   step_ff    <= csr_wdata[15:0];
            CSR_TURN_ANGLE:    turn_ff    <= csr_wdata[9:0];
            CSR_START_X:       start_x_ff <= csr_wdata;
            CSR_START_Y:       start_y_ff <= csr_wdata;
            CSR_START_HEADING: start_h_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // ---------------- turtle state ----------------
   logic signed [23:0] pos_x_ff, pos_y_ff, pos_x_in, pos_y_in;
   logic [8:0]         hdg_ff, hdg_in;
   logic [LW-1:0]      lvl_ff, lvl_in;
   logic signed [23:0] lo_x_ff, hi_x_ff, lo_y_ff, hi_y_ff;
   logic signed [23:0] lo_x_in, hi_x_in, lo_y_in, hi_y_in;

   // ---------------- pipeline control ----------------
   logic   s1_vld_ff, s2_vld_ff, rsp_vld_ff;
   op_type s1_op_ff, s2_op_ff;
   logic   s1_draw_ff, s2_draw_ff;
   logic   req_take, s1_adv, s2_adv, out_free, s2_keeps_turtle;

   // Hold the entry item back while the executing item changes heading or
   // level: its sine lookup and stack read use those registers directly.
   assign out_free        = !rsp_vld_ff || rsp_tready;
   assign s2_adv          = s2_vld_ff && out_free;
   assign s2_keeps_turtle = (s2_op_ff == OP_MOVE) || (s2_op_ff == OP_NONE);
   assign s1_adv          = s1_vld_ff && (!s2_vld_ff || (s2_adv && s2_keeps_turtle));
   assign req_tready      = !s1_vld_ff || s1_adv;
   assign req_take        = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_adv) begin
            s2_vld_ff <= 1'b1;
         end else if (s2_adv) begin
            s2_vld_ff <= 1'b0;
         end
         if (s2_adv) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // ---------------- entry stage: decode ----------------
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= decode_op(req_tuser, req_tdata);
         s1_draw_ff <= (req_tuser == REQ_SYMBOL) && (req_tdata >= SYM_A)
                       && (req_tdata <= SYM_F);
      end
   end

   // ---------------- lookup stage: sine, multiply, stack read ----------------
   logic [8:0]              cos_idx;
   logic signed [15:0]      sin_v, cos_v;
   logic signed [ProdW-1:0] mul_x, mul_y;
   logic signed [31:0]      s2_px_ff, s2_py_ff;

   assign cos_idx = (hdg_ff >= 9'd270) ? (hdg_ff - 9'd270) : (hdg_ff + 9'd90);
   assign sin_v   = sin_q14(hdg_ff);
   assign cos_v   = sin_q14(cos_idx);
   assign mul_x   = ProdW'($signed({1'b0, step_ff})) * ProdW'(cos_v);
   assign mul_y   = ProdW'($signed({1'b0, step_ff})) * ProdW'(sin_v);

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_op_ff   <= s1_op_ff;
         s2_draw_ff <= s1_draw_ff;
         s2_px_ff   <= mul_x;
         s2_py_ff   <= mul_y;
      end
   end

   // stack memory; a pop's read is registered as the pop enters the lookup stage
   logic             stk_wr_en, stk_rd_en;
   logic [AW-1:0]    stk_wr_addr, stk_rd_addr;
   logic [LW-1:0]    lvl_dec;
   turtle_entry_type stk_wr_entry, stk_rd_entry;

   assign lvl_dec      = lvl_ff - LW'(1);
   assign stk_rd_en    = s1_adv && (s1_op_ff == OP_POP);
   assign stk_rd_addr  = lvl_dec[AW-1:0];
   assign stk_wr_addr  = lvl_ff[AW-1:0];
   assign stk_wr_entry = '{x: pos_x_ff, y: pos_y_ff, h: hdg_ff};

   tpi_stack #(
      .DEPTH (STACK_DEPTH),
      .AW    (AW)
   ) u_stack (
      .clock    (clock),
      .wr_en    (stk_wr_en),
      .wr_addr  (stk_wr_addr),
      .wr_entry (stk_wr_entry),
      .rd_en    (stk_rd_en),
      .rd_addr  (stk_rd_addr),
      .rd_entry (stk_rd_entry)
   );

   // ---------------- execute stage ----------------
   logic signed [31:0] rnd_x, rnd_y;
   logic signed [17:0] dx, dy;
   logic signed [25:0] sum_x, sum_y;
   logic signed [11:0] turn_sum, turn_w1, turn_w2, turn_t;
   logic [8:0]         half_h, start_h;
   logic               stk_full, stk_empty;
   stack_err_type      err;
   logic signed [23:0] from_x, from_y;

   // round the Q.22 products to Q.8: add half, floor by arithmetic shift
   assign rnd_x = s2_px_ff + 32'sd8192;
   assign rnd_y = s2_py_ff + 32'sd8192;
   assign dx    = rnd_x[31:14];
   assign dy    = rnd_y[31:14];
   assign sum_x = {{2{pos_x_ff[23]}}, pos_x_ff} + {{8{dx[17]}}, dx};
   assign sum_y = {{2{pos_y_ff[23]}}, pos_y_ff} + {{8{dy[17]}}, dy};

   // heading plus or minus the turn angle, folded back into 0..359
   assign turn_t   = {{2{turn_ff[9]}}, turn_ff};
   assign turn_sum = (s2_op_ff == OP_MINUS) ? ($signed({3'b000, hdg_ff}) - turn_t)
                                            : ($signed({3'b000, hdg_ff}) + turn_t);
   always_comb begin
      if (turn_sum < 12'sd0) begin
         turn_w1 = turn_sum + 12'sd360;
      end else if (turn_sum >= 12'sd360) begin
         turn_w1 = turn_sum - 12'sd360;
      end else begin
         turn_w1 = turn_sum;
      end
      if (turn_w1 < 12'sd0) begin
         turn_w2 = turn_w1 + 12'sd360;
      end else if (turn_w1 >= 12'sd360) begin
         turn_w2 = turn_w1 - 12'sd360;
      end else begin
         turn_w2 = turn_w1;
      end
   end

   assign half_h    = (hdg_ff >= 9'd180) ? (hdg_ff - 9'd180) : (hdg_ff + 9'd180);
   assign start_h   = (start_h_ff >= 9'd360) ? (start_h_ff - 9'd360) : start_h_ff;
   assign stk_full  = (lvl_ff == LW'(STACK_DEPTH));
   assign stk_empty = (lvl_ff == '0);
   assign stk_wr_en = s2_adv && (s2_op_ff == OP_PUSH) && !stk_full;

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      hdg_in   = hdg_ff;
      lvl_in   = lvl_ff;
      err      = ERR_NONE;
      case (s2_op_ff)
         OP_MOVE: begin
            pos_x_in = sat24(sum_x);
            pos_y_in = sat24(sum_y);
         end
         OP_HALF: begin
            hdg_in = half_h;
         end
         OP_PLUS, OP_MINUS: begin
            hdg_in = turn_w2[8:0];
         end
         OP_PUSH: begin
            if (stk_full) begin
               err = ERR_FULL;
            end else begin
               lvl_in = lvl_ff + LW'(1);
            end
         end
         OP_POP: begin
            if (stk_empty) begin
               err = ERR_EMPTY;
            end else begin
               lvl_in   = lvl_dec;
               pos_x_in = stk_rd_entry.x;
               pos_y_in = stk_rd_entry.y;
               hdg_in   = stk_rd_entry.h;
            end
         end
         OP_RESTART: begin
            pos_x_in = start_x_ff;
            pos_y_in = start_y_ff;
            hdg_in   = start_h;
            lvl_in   = '0;
         end
         default: ;
      endcase
   end

   // box takes in every new position; restart collapses it onto the start
   always_comb begin
      if (s2_op_ff == OP_RESTART) begin
         lo_x_in = start_x_ff;
         hi_x_in = start_x_ff;
         lo_y_in = start_y_ff;
         hi_y_in = start_y_ff;
         from_x  = start_x_ff;
         from_y  = start_y_ff;
      end else begin
         lo_x_in = (pos_x_in < lo_x_ff) ? pos_x_in : lo_x_ff;
         hi_x_in = (pos_x_in > hi_x_ff) ? pos_x_in : hi_x_ff;
         lo_y_in = (pos_y_in < lo_y_ff) ? pos_y_in : lo_y_ff;
         hi_y_in = (pos_y_in > hi_y_ff) ? pos_y_in : hi_y_ff;
         from_x  = pos_x_ff;
         from_y  = pos_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= START_X_RST;
         pos_y_ff <= START_Y_RST;
         hdg_ff   <= START_HEADING_RST;
         lvl_ff   <= '0;
         lo_x_ff  <= START_X_RST;
         hi_x_ff  <= START_X_RST;
         lo_y_ff  <= START_Y_RST;
         hi_y_ff  <= START_Y_RST;
      end else if (s2_adv) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         hdg_ff   <= hdg_in;
         lvl_ff   <= lvl_in;
         lo_x_ff  <= lo_x_in;
         hi_x_ff  <= hi_x_in;
         lo_y_ff  <= lo_y_in;
         hi_y_ff  <= hi_y_in;
      end
   end

   // ---------------- output register ----------------
   logic [207:0] rsp_data_ff;
   logic [0:0]   rsp_user_ff;

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_user_ff <= s2_draw_ff;
         rsp_data_ff <= {5'b00000, err, hi_y_in, lo_y_in, hi_x_in, lo_x_in, hdg_in,
                         pos_y_in, pos_x_in, from_y, from_x};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---------------- assertions ----------------
   `TPI_ASSERT_IMP(a_push_interlock, clock, reset,
      s2_vld_ff && (s2_op_ff == OP_PUSH || s2_op_ff == OP_POP), !s1_adv,
      "lookup stage advanced behind a stack operation")
   `TPI_ASSERT_IMP(a_level_bound, clock, reset,
      1'b1, lvl_ff <= LW'(STACK_DEPTH),
      "stack level beyond stack depth")
   `TPI_ASSERT_IMP(a_err_no_line, clock, reset,
      rsp_vld_ff && (rsp_data_ff[202:201] != ERR_NONE), rsp_user_ff == 1'b0,
      "stack error reported together with a drawn line")
   `TPI_ASSERT_NXT(a_exec_held, clock, reset,
      s2_vld_ff && !out_free, s2_vld_ff,
      "executing item dropped while the output was stalled")

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Turtle path interpreter testbench
// Streams directed and random L-system symbol items into the interpreter
// under several register settings, predicts every result item with an
// independent turtle model held in a scoreboard and compares each field.
// ---------------------------------------------------------------------------
module testbench;
   import tpi_pkg::*;

   localparam int StackDepth = 64;
   localparam int Latency    = 2;
   localparam int CycleLimit = 400000;

   // result item as it appears on rsp_tdata, last field (from_x) in the lowest bits
   typedef struct packed {
      logic [4:0]         pad;
      logic [1:0]         err;
      logic signed [23:0] max_y;
      logic signed [23:0] min_y;
      logic signed [23:0] max_x;
      logic signed [23:0] min_x;
      logic [8:0]         hdg;
      logic signed [23:0] to_y;
      logic signed [23:0] to_x;
      logic signed [23:0] from_y;
      logic signed [23:0] from_x;
   } path_word_type;

   typedef struct {
      logic          drawn;
      path_word_type word;
   } path_result_type;

   // Turtle model plus the queue of result items still owed by the block.
   class path_scoreboard;
      logic [15:0]        step_len;
      logic signed [9:0]  turn;
      logic signed [23:0] home_x;
      logic signed [23:0] home_y;
      logic [8:0]         home_hdg;
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] lo_x;
      logic signed [23:0] hi_x;
      logic signed [23:0] lo_y;
      logic signed [23:0] hi_y;
      logic [8:0]         hdg;
      turtle_entry_type   saved [StackDepth];
      int                 depth;
      path_result_type    predicted_paths [$];
      int                 errors;

      function new();
         step_len = STEP_LENGTH_RST;
         turn     = TURN_ANGLE_RST;
         home_x   = START_X_RST;
         home_y   = START_Y_RST;
         home_hdg = START_HEADING_RST;
         errors   = 0;
         go_home();
      endfunction

      function void go_home();
         x     = home_x;
         y     = home_y;
         hdg   = 9'(int'(home_hdg) % 360);
         lo_x  = x;
         hi_x  = x;
         lo_y  = y;
         hi_y  = y;
         depth = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [23:0] val);
         case (idx)
            CSR_STEP_LENGTH:   step_len = val[15:0];
            CSR_TURN_ANGLE:    turn     = val[9:0];
            CSR_START_X:       home_x   = val;
            CSR_START_Y:       home_y   = val;
            CSR_START_HEADING: home_hdg = val[8:0];
            default: ;
         endcase
      endfunction

      function op_type classify(logic [0:0] kind, logic [7:0] sym);
         if (kind == REQ_RESTART) return OP_RESTART;
         if (sym >= SYM_A && sym <= SYM_L) return OP_MOVE;
         case (sym)
            SYM_BAR:   return OP_HALF;
            SYM_PLUS:  return OP_PLUS;
            SYM_MINUS: return OP_MINUS;
            SYM_OPEN:  return OP_PUSH;
            SYM_CLOSE: return OP_POP;
            default:   return OP_NONE;
         endcase
      endfunction

      // Q1.14 sine, folded onto the quarter wave
      function int sine_of(int d);
         int a;
         a = d % 360;
         if (a <= 90) return int'(QUARTER_SINE[a]);
         if (a <= 180) return int'(QUARTER_SINE[180 - a]);
         if (a <= 270) return -int'(QUARTER_SINE[a - 180]);
         return -int'(QUARTER_SINE[360 - a]);
      endfunction

      function logic signed [23:0] clip_pos(longint v);
         if (v > 64'sd8388607) return 24'sh7FFFFF;
         if (v < -64'sd8388608) return 24'sh800000;
         return v[23:0];
      endfunction

      // step of one axis: Q8.8 length times Q1.14 factor, rounded back to Q.8
      function longint step_delta(int factor);
         return (longint'(step_len) * factor + 8192) >>> 14;
      endfunction

      function void predict_symbol(logic [0:0] kind, logic [7:0] sym);
         path_result_type r;
         op_type          op;
         int              h;
         r.drawn       = 1'b0;
         r.word        = '0;
         r.word.err    = ERR_NONE;
         r.word.from_x = x;
         r.word.from_y = y;
         op = classify(kind, sym);
         case (op)
            OP_RESTART: begin
               go_home();
               r.word.from_x = x;
               r.word.from_y = y;
            end
            OP_MOVE: begin
               x = clip_pos(longint'(x) + step_delta(sine_of(int'(hdg) + 90)));
               y = clip_pos(longint'(y) + step_delta(sine_of(int'(hdg))));
               r.drawn = (sym <= SYM_F);
            end
            OP_HALF: hdg = 9'((int'(hdg) + 180) % 360);
            OP_PLUS, OP_MINUS: begin
               h = int'(hdg) + ((op == OP_PLUS) ? int'(turn) : -int'(turn));
               h = h % 360;
               if (h < 0) h += 360;
               hdg = 9'(h);
            end
            OP_PUSH: begin
               if (depth < StackDepth) begin
                  saved[depth].x = x;
                  saved[depth].y = y;
                  saved[depth].h = hdg;
                  depth++;
               end else begin
                  r.word.err = ERR_FULL;
               end
            end
            OP_POP: begin
               if (depth > 0) begin
                  depth--;
                  x   = saved[depth].x;
                  y   = saved[depth].y;
                  hdg = saved[depth].h;
               end else begin
                  r.word.err = ERR_EMPTY;
               end
            end
            default: ;
         endcase
         if (op != OP_RESTART) begin
            if (x > hi_x) hi_x = x;
            if (y > hi_y) hi_y = y;
            if (x < lo_x) lo_x = x;
            if (y < lo_y) lo_y = y;
         end
         r.word.to_x  = x;
         r.word.to_y  = y;
         r.word.hdg   = hdg;
         r.word.min_x = lo_x;
         r.word.max_x = hi_x;
         r.word.min_y = lo_y;
         r.word.max_y = hi_y;
         predicted_paths.push_back(r);
      endfunction

      function void compare_field(string name, logic [23:0] want, logic [23:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [207:0] data, logic [0:0] user);
         path_result_type e;
         path_word_type   a;
         if (predicted_paths.size() == 0) begin
            $display("%0t: result item with nothing expected, expected none, actual %h",
                     $time, data);
            errors++;
            return;
         end
         e = predicted_paths.pop_front();
         a = data;
         compare_field("line_drawn", 24'(e.drawn), 24'(user));
         compare_field("from_x", e.word.from_x, a.from_x);
         compare_field("from_y", e.word.from_y, a.from_y);
         compare_field("to_x", e.word.to_x, a.to_x);
         compare_field("to_y", e.word.to_y, a.to_y);
         compare_field("heading_now", 24'(e.word.hdg), 24'(a.hdg));
         compare_field("box_min_x", e.word.min_x, a.min_x);
         compare_field("box_max_x", e.word.max_x, a.max_x);
         compare_field("box_min_y", e.word.min_y, a.min_y);
         compare_field("box_max_y", e.word.max_y, a.max_y);
         compare_field("stack_error", 24'(e.word.err), 24'(a.err));
         compare_field("tdata padding", 24'(e.word.pad), 24'(a.pad));
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;    // [7:0] symbol
   logic [0:0]   req_tuser;    // [0] req_type
   logic         rsp_tvalid;
   logic         rsp_tready;
   // [23:0] from_x, [47:24] from_y, [71:48] to_x, [95:72] to_y,
   // [104:96] heading_now, [128:105] box_min_x, [152:129] box_max_x,
   // [176:153] box_min_y, [200:177] box_max_y, [202:201] stack_error
   logic [207:0] rsp_tdata;
   logic [0:0]   rsp_tuser;    // [0] line_drawn
   logic         csr_wr_en;
   logic [2:0]   csr_index;
   logic [23:0]  csr_wdata;

   path_scoreboard sb;
   int             idle_odds;   // one in idle_odds chance of a burst, 0 for none
   int             cycle_count;

   turtle_path_interpreter #(
      .STACK_DEPTH(StackDepth)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Receiver: hold tready low in random bursts, change it on the falling edge.
   initial begin
      int hold;
      hold       = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready = 1'b0;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            hold       = $urandom_range(1, 18) - 1;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Check every result item on the rising edge that accepts it.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Watchdog: give up well past the slowest correct run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench failed");
      $finish;
   end

   // Offer one item, hold it until the block takes it, then note it for
   // prediction. Returns on the falling edge after acceptance.
   task automatic send_item(input logic [0:0] kind, input logic [7:0] sym);
      int gap;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         gap        = $urandom_range(1, 18);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = sym;
      req_tuser  = kind;
      do @(posedge clock); while (!req_tready);
      sb.predict_symbol(kind, sym);
      @(negedge clock);
   endtask

   // Stop sending and wait until every predicted item has come back.
   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.predicted_paths.size() != 0) @(negedge clock);
      repeat (Latency + 4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [23:0] val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Registers change only once the block has gone idle.
   task automatic configure(input logic [23:0] step, input logic [23:0] turn,
                            input logic [23:0] sx, input logic [23:0] sy,
                            input logic [23:0] sh);
      drain();
      write_csr(CSR_STEP_LENGTH, step);
      write_csr(CSR_TURN_ANGLE, turn);
      write_csr(CSR_START_X, sx);
      write_csr(CSR_START_Y, sy);
      write_csr(CSR_START_HEADING, sh);
   endtask

   // Mostly well-formed L-system text with random content; a little noise,
   // stray closing brackets and restarts. Ignored symbols are not counted.
   task automatic play_random(input int n);
      int         made;
      int         r;
      logic [7:0] sym;
      logic [0:0] kind;
      made = 0;
      while (made < n) begin
         r    = $urandom_range(0, 99);
         kind = REQ_SYMBOL;
         sym  = 8'($urandom_range(0, 255));
         if (r < 2) begin
            kind = REQ_RESTART;
         end else if (r < 8) begin
            // keep the random symbol as noise
         end else if (r < 10) begin
            sym = SYM_CLOSE;
         end else if (r < 48) begin
            sym = 8'(SYM_A + 8'($urandom_range(0, 11)));
         end else if (r < 60) begin
            sym = SYM_PLUS;
         end else if (r < 72) begin
            sym = SYM_MINUS;
         end else if (r < 76) begin
            sym = SYM_BAR;
         end else if (r < 88) begin
            sym = (sb.depth < 12) ? SYM_OPEN : SYM_CLOSE;
         end else begin
            sym = (sb.depth > 0) ? SYM_CLOSE : SYM_OPEN;
         end
         send_item(kind, sym);
         if (sb.classify(kind, sym) != OP_NONE) made++;
      end
   endtask

   // Nest past the stack depth, then unwind past empty.
   task automatic grow_deep_branch();
      int i;
      send_item(REQ_RESTART, 8'h00);
      for (i = 0; i < StackDepth + 6; i++) begin
         send_item(REQ_SYMBOL, SYM_OPEN);
         send_item(REQ_SYMBOL, ($urandom_range(0, 1) == 1) ? SYM_PLUS
                                : 8'(SYM_A + 8'($urandom_range(0, 11))));
      end
      for (i = 0; i < StackDepth + 6; i++) begin
         send_item(REQ_SYMBOL, SYM_CLOSE);
         if ($urandom_range(0, 2) == 0) send_item(REQ_SYMBOL, SYM_F);
      end
   endtask

   initial begin
      int k;
      sb         = new();
      idle_odds  = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_SYMBOL;
      csr_wr_en  = 1'b0;
      csr_index  = CSR_STEP_LENGTH;
      csr_wdata  = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // Directed: every operation from the reset turtle, then the odd cases.
      idle_odds = 6;
      send_item(REQ_SYMBOL, SYM_F);
      send_item(REQ_SYMBOL, SYM_A);
      send_item(REQ_SYMBOL, SYM_L);            // moves without a line
      send_item(REQ_SYMBOL, SYM_PLUS);
      send_item(REQ_SYMBOL, SYM_F);
      send_item(REQ_SYMBOL, SYM_MINUS);
      send_item(REQ_SYMBOL, SYM_BAR);
      send_item(REQ_SYMBOL, SYM_OPEN);
      send_item(REQ_SYMBOL, 8'(SYM_F + 8'd1));
      send_item(REQ_SYMBOL, SYM_PLUS);
      send_item(REQ_SYMBOL, SYM_CLOSE);        // back to the saved turtle
      send_item(REQ_SYMBOL, SYM_CLOSE);        // pop on an empty stack
      send_item(REQ_SYMBOL, 8'h61);            // lowercase letter: no effect
      send_item(REQ_SYMBOL, 8'(SYM_A - 8'd1)); // just below the move range
      send_item(REQ_SYMBOL, 8'(SYM_L + 8'd1)); // just above it
      send_item(REQ_SYMBOL, 8'h00);
      send_item(REQ_SYMBOL, 8'hFF);
      send_item(REQ_RESTART, SYM_F);           // restart ignores the symbol
      send_item(REQ_SYMBOL, 8'(SYM_A + 8'd4));
      send_item(REQ_RESTART, 8'hFF);
      send_item(REQ_SYMBOL, SYM_CLOSE);

      play_random(250);
      drain();                                 // hold off until all results are in
      play_random(250);

      // Zero step, most negative turn, corner start, heading above 359.
      configure(24'h000000, 24'h000200, 24'h800000, 24'h7FFFFF, 24'h0001FF);
      send_item(REQ_RESTART, 8'h00);
      play_random(150);

      // Longest step from the opposite corner: drives saturation.
      configure(24'h00FFFF, 24'h0001FF, 24'h7FFFFF, 24'h800000, 24'h000000);
      idle_odds = 3;
      send_item(REQ_RESTART, 8'h00);
      send_item(REQ_SYMBOL, SYM_F);
      send_item(REQ_SYMBOL, SYM_BAR);
      send_item(REQ_SYMBOL, SYM_PLUS);
      send_item(REQ_SYMBOL, SYM_F);
      play_random(150);

      configure(24'($urandom_range(0, 2047)), 24'd90, 24'd0, 24'd0, 24'd359);
      idle_odds = 10;
      grow_deep_branch();

      for (k = 0; k < 3; k++) begin
         configure(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                   24'($urandom));
         idle_odds = 2 + 4 * k;
         send_item(REQ_RESTART, 8'($urandom_range(0, 255)));
         play_random(80);
      end

      // Last stretch at full rate on both sides.
      configure(24'($urandom_range(0, 4095)), 24'($urandom), 24'($urandom),
                24'($urandom), 24'($urandom_range(0, 359)));
      idle_odds = 0;
      send_item(REQ_RESTART, 8'h00);
      play_random(250);
      drain();

      if (sb.errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/tpi_pkg.sv
hw/rtl/tpi_stack.sv
hw/rtl/turtle_path_interpreter.sv
test/testbench.sv
